@@ rtl/iec_pkg.sv @@
// Shared types and constants for the input event concentrator.
package iec_pkg;

	localparam int MODE_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int KEY_W = 32;
	localparam int COORD_W = 16;
	localparam int PANEL_W = 15;
	localparam int STEPS_W = 16;
	localparam int CLICK_W = 8;

	localparam logic [MODE_W-1:0] MODE_POINTER = 3'd0;
	localparam logic [MODE_W-1:0] MODE_KEY_PUSH = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WHEEL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_KEY_POP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ENC_READ = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_AS_KEYS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_KEY_CODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_KEY_CODE = 3'd4;

	localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST = 15'd800;
	localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 15'd480;
	localparam logic [KEY_W-1:0] UP_KEY_RST = 32'd17;
	localparam logic [KEY_W-1:0] DOWN_KEY_RST = 32'd18;

	localparam logic signed [STEPS_W+1:0] STEPS_MAX = 18'sd32767;
	localparam logic signed [STEPS_W+1:0] STEPS_MIN = -18'sd32768;

	typedef struct packed {
		logic press;
		logic [KEY_W-1:0] code;
	} key_entry_t;

endpackage

@@ rtl/input_event_concentrator.sv @@
// Input event concentrator: pointer clamp, key ring in RAM, wheel to encoder or key pairs.
// Every accepted item passes through the response state, which raises done; wheel in key
// mode first writes a press and a release per rounded click (one ring write per cycle).
// A new item is accepted only while idle; busy stays high until done.
// The key ring is a single-port-write RAM with a registered read; it is not cleared.
// Reset clears pointers, encoder count, stored pointer and registers to defaults.
// The receiver cannot stall: done is high for exactly one cycle per item.
module input_event_concentrator #(
	parameter int RING_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [iec_pkg::MODE_W-1:0]        mode,
	input  logic signed [iec_pkg::COORD_W-1:0] pos_x,
	input  logic signed [iec_pkg::COORD_W-1:0] pos_y,
	input  logic                              pressed,
	input  logic [iec_pkg::KEY_W-1:0]         key_in,
	input  logic signed [iec_pkg::COORD_W-1:0] wheel_delta,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [iec_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [iec_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              done,
	output logic                              key_valid,
	output logic [iec_pkg::KEY_W-1:0]         key_out,
	output logic                              key_out_pressed,
	output logic                              more_keys,
	output logic signed [iec_pkg::STEPS_W-1:0] encoder_steps,
	output logic [iec_pkg::PANEL_W-1:0]       pointer_x,
	output logic [iec_pkg::PANEL_W-1:0]       pointer_y,
	output logic                              pointer_pressed
);
	import iec_pkg::*;

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
	localparam logic [PW-1:0] SPAN_LAST = PW'(2 * RING_DEPTH - 1);
	localparam int PCNT_W = CLICK_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH,
		S_RESP
	} state_t;

	state_t state_q;

	// configuration
	logic [PANEL_W-1:0] panel_w_q, panel_h_q;
	logic wheel_keys_q;
	logic [KEY_W-1:0] up_key_q, down_key_q;

	// block state
	logic [PW-1:0] head_q, tail_q;
	logic signed [STEPS_W-1:0] accum_q;
	logic [PANEL_W-1:0] stored_x_q, stored_y_q;
	logic stored_press_q;

	logic [MODE_W-1:0] mode_q;
	logic pop_valid_q;
	logic [PCNT_W-1:0] push_cnt_q;
	logic [KEY_W-1:0] push_key_q;
	logic push_press_q;

	// key ring
	key_entry_t ring_mem [RING_DEPTH];
	key_entry_t rd_data_q;
	key_entry_t mem_wdata;
	logic mem_we;
	logic [AW-1:0] mem_waddr;

	// result registers
	logic done_q, key_valid_q, key_press_q, more_q;
	logic [KEY_W-1:0] key_out_q;
	logic signed [STEPS_W-1:0] steps_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == SPAN_LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
		return (p >= DEPTH_P) ? AW'(p - DEPTH_P) : AW'(p);
	endfunction

	logic accept;
	logic [PW-1:0] fill;
	logic ring_empty, ring_full;
	logic [PANEL_W-1:0] w_eff, h_eff, clamp_x, clamp_y;
	logic in_panel;
	logic [COORD_W:0] whl_abs, whl_rnd;
	logic [CLICK_W-1:0] whl_mag;
	logic signed [STEPS_W+1:0] enc_sum;
	logic signed [STEPS_W-1:0] enc_sat;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// fill level modulo twice the depth
	always_comb begin
		if (head_q >= tail_q) begin
			fill = head_q - tail_q;
		end else begin
			fill = PW'(head_q + SPAN_LAST + PW'(1) - tail_q);
		end
	end
	assign ring_empty = (head_q == tail_q);
	assign ring_full = (fill >= DEPTH_P);

	// pointer clamp; zero panel size acts as one
	always_comb begin
		w_eff = (panel_w_q == '0) ? PANEL_W'(1) : panel_w_q;
		h_eff = (panel_h_q == '0) ? PANEL_W'(1) : panel_h_q;
		in_panel = !pos_x[COORD_W-1] && !pos_y[COORD_W-1]
			&& (pos_x[PANEL_W-1:0] < w_eff) && (pos_y[PANEL_W-1:0] < h_eff);
		if (pos_x[COORD_W-1]) begin
			clamp_x = '0;
		end else if (pos_x[PANEL_W-1:0] >= w_eff) begin
			clamp_x = w_eff - PANEL_W'(1);
		end else begin
			clamp_x = pos_x[PANEL_W-1:0];
		end
		if (pos_y[COORD_W-1]) begin
			clamp_y = '0;
		end else if (pos_y[PANEL_W-1:0] >= h_eff) begin
			clamp_y = h_eff - PANEL_W'(1);
		end else begin
			clamp_y = pos_y[PANEL_W-1:0];
		end
	end

	// wheel: round magnitude half away from zero, then saturate the step count
	always_comb begin
		if (wheel_delta[COORD_W-1]) begin
			whl_abs = (COORD_W+1)'(0) - (COORD_W+1)'(wheel_delta);
		end else begin
			whl_abs = (COORD_W+1)'(wheel_delta);
		end
		whl_rnd = whl_abs + (COORD_W+1)'(128);
		whl_mag = CLICK_W'(whl_rnd >> 8);
		if (wheel_delta[COORD_W-1]) begin
			enc_sum = (STEPS_W+2)'(accum_q) + (STEPS_W+2)'(whl_mag);
		end else begin
			enc_sum = (STEPS_W+2)'(accum_q) - (STEPS_W+2)'(whl_mag);
		end
		if (enc_sum > STEPS_MAX) begin
			enc_sat = STEPS_W'(STEPS_MAX);
		end else if (enc_sum < STEPS_MIN) begin
			enc_sat = STEPS_W'(STEPS_MIN);
		end else begin
			enc_sat = STEPS_W'(enc_sum);
		end
	end

	// ring write port
	always_comb begin
		mem_we = (accept && (mode == MODE_KEY_PUSH)) || (state_q == S_PUSH);
		mem_waddr = ptr_slot(head_q);
		if (state_q == S_PUSH) begin
			mem_wdata.press = push_press_q;
			mem_wdata.code = push_key_q;
		end else begin
			mem_wdata.press = pressed;
			mem_wdata.code = key_in;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		if (accept && (mode == MODE_KEY_POP)) begin
			rd_data_q <= ring_mem[ptr_slot(tail_q)];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_w_q <= PANEL_WIDTH_RST;
			panel_h_q <= PANEL_HEIGHT_RST;
			wheel_keys_q <= 1'b0;
			up_key_q <= UP_KEY_RST;
			down_key_q <= DOWN_KEY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PANEL_WIDTH: panel_w_q <= cfg_data[PANEL_W-1:0];
				REG_PANEL_HEIGHT: panel_h_q <= cfg_data[PANEL_W-1:0];
				REG_WHEEL_AS_KEYS: wheel_keys_q <= cfg_data[0];
				REG_UP_KEY_CODE: up_key_q <= cfg_data[KEY_W-1:0];
				REG_DOWN_KEY_CODE: down_key_q <= cfg_data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, block state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			accum_q <= '0;
			stored_x_q <= '0;
			stored_y_q <= '0;
			stored_press_q <= 1'b0;
			mode_q <= MODE_POINTER;
			pop_valid_q <= 1'b0;
			push_cnt_q <= '0;
			push_key_q <= '0;
			push_press_q <= 1'b0;
			done_q <= 1'b0;
			key_valid_q <= 1'b0;
			key_out_q <= '0;
			key_press_q <= 1'b0;
			more_q <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= mode;
						pop_valid_q <= 1'b0;
						state_q <= S_RESP;
						case (mode)
							MODE_POINTER: begin
								stored_x_q <= clamp_x;
								stored_y_q <= clamp_y;
								stored_press_q <= pressed && in_panel;
							end
							MODE_KEY_PUSH: begin
								head_q <= ptr_inc(head_q);
								if (ring_full) begin
									tail_q <= ptr_inc(tail_q);
								end
							end
							MODE_WHEEL: begin
								if (whl_mag != '0) begin
									if (wheel_keys_q) begin
										// each click is a press then a release
										push_cnt_q <= {whl_mag, 1'b0};
										push_key_q <= wheel_delta[COORD_W-1] ? down_key_q
											: up_key_q;
										push_press_q <= 1'b1;
										state_q <= S_PUSH;
									end else begin
										accum_q <= enc_sat;
									end
								end
							end
							MODE_KEY_POP: begin
								if (!ring_empty) begin
									tail_q <= ptr_inc(tail_q);
									pop_valid_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_PUSH: begin
					head_q <= ptr_inc(head_q);
					if (ring_full) begin
						tail_q <= ptr_inc(tail_q);
					end
					push_press_q <= !push_press_q;
					push_cnt_q <= push_cnt_q - PCNT_W'(1);
					if (push_cnt_q == PCNT_W'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					done_q <= 1'b1;
					key_valid_q <= pop_valid_q;
					key_out_q <= pop_valid_q ? rd_data_q.code : '0;
					key_press_q <= pop_valid_q && rd_data_q.press;
					more_q <= !ring_empty;
					steps_q <= accum_q;
					// read and clear
					if (mode_q == MODE_ENC_READ) begin
						accum_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign key_valid = key_valid_q;
	assign key_out = key_out_q;
	assign key_out_pressed = key_press_q;
	assign more_keys = more_q;
	assign encoder_steps = steps_q;
	assign pointer_x = stored_x_q;
	assign pointer_y = stored_y_q;
	assign pointer_pressed = stored_press_q;

endmodule

@@ rtl/iec_checker.sv @@
// Port-level checks for the input event concentrator, bound to the top level.
module iec_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         key_valid,
	input logic [iec_pkg::KEY_W-1:0]    key_out,
	input logic                         key_out_pressed
);
	import iec_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high in done cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		done && !key_valid |-> (key_out == '0) && !key_out_pressed)
		else $error("key fields not zero without a popped key");

endmodule

bind input_event_concentrator iec_checker u_iec_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.key_valid(key_valid),
	.key_out(key_out),
	.key_out_pressed(key_out_pressed)
);
